>>> hw/rtl/npr_pkg.sv
package npr_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int CNT_W        = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] HDR_LEN   = CNT_W'(HEADER_BYTES);

  // minimum lengths for each stage of the decode
  localparam logic [CNT_W-1:0] LEN_VERSION = CNT_W'(2);
  localparam logic [CNT_W-1:0] LEN_RESULT  = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_EPOCH   = CNT_W'(8);
  localparam logic [CNT_W-1:0] LEN_EXT     = CNT_W'(12);
  localparam logic [CNT_W-1:0] LEN_MAP     = CNT_W'(16);

  localparam logic [7:0] RESPONSE_BIT = 8'h80;
  localparam logic [7:0] OPCODE_MASK  = 8'h7F;

  localparam logic [15:0] RC_UNSUPP_VERSION = 16'd1;

  localparam logic [6:0] OP_EXT_ADDR = 7'd0;
  localparam logic [6:0] OP_MAP_UDP  = 7'd1;
  localparam logic [6:0] OP_MAP_TCP  = 7'd2;

  typedef enum logic [1:0] {
    KIND_VERSION_ERR = 2'd0,
    KIND_EXT_ADDR    = 2'd1,
    KIND_MAP         = 2'd2,
    KIND_UNKNOWN     = 2'd3
  } kind_t;

  typedef logic [HEADER_BYTES-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    logic        accepted;
    kind_t       reply_kind;
    logic [7:0]  version_seen;
    logic [7:0]  opcode_seen;
    logic [15:0] result_code;
    logic [31:0] epoch_seconds;
    logic [31:0] external_address;
    logic [15:0] internal_port;
    logic [15:0] mapped_port;
    logic [31:0] lifetime_seconds;
  } reply_t;

endpackage

>>> hw/rtl/npr_if.sv
interface npr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface npr_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  reply_kind;
  logic [7:0]  version_seen;
  logic [7:0]  opcode_seen;
  logic [15:0] result_code;
  logic [31:0] epoch_seconds;
  logic [31:0] external_address;
  logic [15:0] internal_port;
  logic [15:0] mapped_port;
  logic [31:0] lifetime_seconds;

  modport source (
    output valid, input ready,
    output accepted, output reply_kind, output version_seen, output opcode_seen,
    output result_code, output epoch_seconds, output external_address,
    output internal_port, output mapped_port, output lifetime_seconds
  );
  modport sink (
    input valid, output ready,
    input accepted, input reply_kind, input version_seen, input opcode_seen,
    input result_code, input epoch_seconds, input external_address,
    input internal_port, input mapped_port, input lifetime_seconds
  );
endinterface

>>> hw/rtl/npr_decode.sv
module npr_decode
  import npr_pkg::*;
(
  input  hdr_bytes_t       hdr,
  input  logic [CNT_W-1:0] len,
  output reply_t           reply
);

  logic [7:0]  ver;
  logic [7:0]  op;
  logic [15:0] rc;
  logic        rc_verr;

  assign ver     = hdr[0];
  assign op      = hdr[1];
  assign rc      = {hdr[2], hdr[3]};
  assign rc_verr = (rc == RC_UNSUPP_VERSION);

  always_comb begin
    reply = '0;
    if (len >= LEN_VERSION) begin
      if (ver != 8'd0) begin
        reply.accepted     = 1'b1;
        reply.reply_kind   = KIND_VERSION_ERR;
        reply.version_seen = ver;
        reply.opcode_seen  = op;
        reply.result_code  = RC_UNSUPP_VERSION;
      end else if (len >= LEN_RESULT && ((op & RESPONSE_BIT) != 8'd0 || rc_verr)) begin
        reply.version_seen = ver;
        reply.opcode_seen  = op;
        reply.result_code  = rc;
        if (len >= LEN_EPOCH) begin
          reply.epoch_seconds = {hdr[4], hdr[5], hdr[6], hdr[7]};
        end
        if (rc_verr) begin
          reply.accepted   = 1'b1;
          reply.reply_kind = KIND_VERSION_ERR;
        end else begin
          unique case (op[6:0] & OPCODE_MASK[6:0]) inside
            OP_EXT_ADDR: begin
              if (len >= LEN_EXT) begin
                reply.accepted         = 1'b1;
                reply.reply_kind       = KIND_EXT_ADDR;
                reply.external_address = {hdr[8], hdr[9], hdr[10], hdr[11]};
              end else begin
                reply = '0;
              end
            end
            OP_MAP_UDP, OP_MAP_TCP: begin
              if (len >= LEN_MAP) begin
                reply.accepted         = 1'b1;
                reply.reply_kind       = KIND_MAP;
                reply.internal_port    = {hdr[8], hdr[9]};
                reply.mapped_port      = {hdr[10], hdr[11]};
                reply.lifetime_seconds = {hdr[12], hdr[13], hdr[14], hdr[15]};
              end else begin
                reply = '0;
              end
            end
            default: begin
              reply.accepted   = 1'b1;
              reply.reply_kind = KIND_UNKNOWN;
            end
          endcase
        end
      end
    end
  end

endmodule

>>> hw/rtl/nat_pmp_reply_parser_core.sv
// Reply parser: takes one datagram byte per cycle and, for every byte marked
// last, delivers one verdict item on the output channel. The first 16 bytes
// land in a header register bank; the verdict is decoded from that bank and
// registered after the last byte sets the pending flag. Bytes flow at one per
// cycle without gaps, including straight from one datagram into the next;
// the input stalls only while a decoded verdict is waiting and the output
// register is still held by an earlier verdict that has not been taken.
module nat_pmp_reply_parser_core
  import npr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  npr_in_if.sink    in_ch,
  npr_out_if.source out_ch
);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] len_next;
  hdr_bytes_t       hdr;
  logic             pend;
  logic [CNT_W-1:0] pend_len;
  reply_t           dec;
  reply_t           reply;
  logic             out_valid;
  logic             stall;
  logic             take;

  assign stall    = out_valid && !out_ch.ready;
  assign in_ch.ready = !(pend && stall);
  assign take     = in_ch.valid && in_ch.ready;
  assign len_next = (byte_count != COUNT_MAX) ? byte_count + CNT_W'(1) : COUNT_MAX;

  npr_decode u_decode (
    .hdr   (hdr),
    .len   (pend_len),
    .reply (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        byte_count <= in_ch.last_byte ? '0 : len_next;
      end
      if (take) begin
        pend <= in_ch.last_byte;
      end else if (!stall) begin
        pend <= 1'b0;
      end
      if (!stall) begin
        out_valid <= pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && byte_count < HDR_LEN) begin
      hdr[byte_count[HDR_IDX_W-1:0]] <= in_ch.data_byte;
    end
    if (take && in_ch.last_byte) begin
      pend_len <= len_next;
    end
    if (pend && !stall) begin
      reply <= dec;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.accepted         = reply.accepted;
  assign out_ch.reply_kind       = reply.reply_kind;
  assign out_ch.version_seen     = reply.version_seen;
  assign out_ch.opcode_seen      = reply.opcode_seen;
  assign out_ch.result_code      = reply.result_code;
  assign out_ch.epoch_seconds    = reply.epoch_seconds;
  assign out_ch.external_address = reply.external_address;
  assign out_ch.internal_port    = reply.internal_port;
  assign out_ch.mapped_port      = reply.mapped_port;
  assign out_ch.lifetime_seconds = reply.lifetime_seconds;

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    take && in_ch.last_byte |=> byte_count == '0)
    else $error("byte count not cleared after last byte");

  a_pend_blocks: assert property (@(posedge clk) disable iff (rst)
    pend && stall |-> !in_ch.ready)
    else $error("input taken while a verdict is blocked");

  a_pend_moves: assert property (@(posedge clk) disable iff (rst)
    pend && !stall |=> out_valid)
    else $error("pending verdict lost");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reply.accepted |-> reply == '0)
    else $error("rejection carries nonzero fields");

  a_map_opcode: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply.accepted && reply.reply_kind == KIND_MAP |->
      (reply.opcode_seen[6:0] == OP_MAP_UDP || reply.opcode_seen[6:0] == OP_MAP_TCP))
    else $error("map verdict with wrong opcode");

endmodule
